[rtl/core/qph_pkg.sv]
package qph_pkg;

	localparam int ACT_W   = 2;
	localparam int KEY_W   = 32;
	localparam int SIZE_W  = 11;
	localparam int SLOT_W  = 10;
	localparam int CNT_W   = 11;
	localparam int STAT_W  = 2;
	localparam int TAG_W   = 2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;

	typedef logic [ACT_W-1:0]  action_t;
	typedef logic [STAT_W-1:0] status_t;
	typedef logic [TAG_W-1:0]  tag_t;

	localparam action_t ACT_INSERT = 2'd0;
	localparam action_t ACT_SEARCH = 2'd1;
	localparam action_t ACT_DELETE = 2'd2;
	localparam action_t ACT_NOP    = 2'd3;

	localparam status_t ST_DONE    = 2'd0;
	localparam status_t ST_FULL    = 2'd1;
	localparam status_t ST_NO_SLOT = 2'd2;
	localparam status_t ST_MISS    = 2'd3;

	localparam tag_t TAG_EMPTY = 2'd0;
	localparam tag_t TAG_USED  = 2'd1;
	localparam tag_t TAG_GONE  = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic    load_req;
		logic    div_start;
		logic    probe_init;
		logic    mem_rd;
		logic    probe_next;
		logic    wr_ins;
		logic    wr_del;
		logic    clr_wr;
		logic    rsp_load;
		status_t rsp_status;
		logic    rsp_found;
		logic    rsp_use_slot;
	} qph_cmd_t;

	// datapath to controller
	typedef struct packed {
		action_t action;
		logic    div_done;
		logic    clr_last;
		tag_t    tag;
		logic    key_match;
		logic    probe_last;
		logic    is_full;
		logic    out_free;
	} qph_sts_t;

endpackage

[rtl/core/qph_req_if.sv]
interface qph_req_if;
	logic                                valid;
	logic                                ready;
	logic [qph_pkg::ACT_W-1:0]           action;
	logic signed [qph_pkg::KEY_W-1:0]    key;

	modport source (output valid, output action, output key, input ready);
	modport sink (input valid, input action, input key, output ready);
endinterface

[rtl/core/qph_rsp_if.sv]
interface qph_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [qph_pkg::STAT_W-1:0]     status;
	logic                           found;
	logic [qph_pkg::SLOT_W-1:0]     slot_index;
	logic [qph_pkg::CNT_W-1:0]      entry_count;

	modport source (output valid, output status, output found, output slot_index,
		output entry_count, input ready);
	modport sink (input valid, input status, input found, input slot_index,
		input entry_count, output ready);
endinterface

[rtl/core/qph_rem_div.sv]
module qph_rem_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [qph_pkg::KEY_W-1:0]     dividend,
	input  logic [qph_pkg::SIZE_W-1:0]    divisor,
	output logic                          done,
	output logic [qph_pkg::SIZE_W-1:0]    rem
);
	import qph_pkg::*;

	localparam int CntW = $clog2(KEY_W);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [KEY_W-1:0]  dvd_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W:0]   trial;
	logic [SIZE_W:0]   trial_sub;

	// one quotient bit per cycle, only the remainder is kept
	assign trial     = {rem_q, dvd_q[KEY_W-1]};
	assign trial_sub = trial - {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(KEY_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[KEY_W-2:0], 1'b0};
			rem_q <= (trial >= {1'b0, divisor}) ? trial_sub[SIZE_W-1:0] : trial[SIZE_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

[rtl/core/qph_dp.sv]
module qph_dp #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  qph_pkg::qph_cmd_t                 cmd,
	output qph_pkg::qph_sts_t                 sts,
	input  logic                              cfg_wr_en,
	input  logic [qph_pkg::SIZE_W-1:0]        cfg_wr_data,
	input  logic [qph_pkg::ACT_W-1:0]         in_action,
	input  logic signed [qph_pkg::KEY_W-1:0]  in_key,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [qph_pkg::STAT_W-1:0]        out_status,
	output logic                              out_found,
	output logic [qph_pkg::SLOT_W-1:0]        out_slot_index,
	output logic [qph_pkg::CNT_W-1:0]         out_entry_count
);
	import qph_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int WordW = TAG_W + KEY_W;
	localparam logic [SIZE_W-1:0] SizeCap =
		SIZE_W'((TABLE_DEPTH > 2047) ? 2047 : TABLE_DEPTH);
	localparam logic [AW-1:0] ClrLast = AW'(TABLE_DEPTH - 1);

	logic [SIZE_W-1:0] table_size_q;
	logic [SIZE_W-1:0] act_size;
	action_t           action_q;
	logic [KEY_W-1:0]  key_q;
	logic [KEY_W-1:0]  key_mag;
	logic [CNT_W-1:0]  count_q;
	logic [SIZE_W-1:0] pos_q;
	logic [SIZE_W-1:0] step_q;
	logic [SIZE_W-1:0] iter_q;
	logic [AW-1:0]     clr_q;
	logic [WordW-1:0]  rd_q;
	logic [WordW-1:0]  mem [TABLE_DEPTH];
	logic              div_done;
	logic [SIZE_W-1:0] home;
	logic [SIZE_W:0]   pos_sum;
	logic [SIZE_W-1:0] pos_nxt;
	logic [SIZE_W:0]   step_a;
	logic [SIZE_W:0]   step_b;
	logic [SIZE_W-1:0] step_nxt;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [WordW-1:0]  mem_wdata;
	logic              out_valid_q;
	status_t           out_status_q;
	logic              out_found_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [CNT_W-1:0]  out_count_q;

	assign act_size = (table_size_q == '0) ? SIZE_W'(1) :
		((table_size_q > SizeCap) ? SizeCap : table_size_q);

	assign key_mag = key_q[KEY_W-1] ? (~key_q + 1'b1) : key_q;

	qph_rem_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (key_mag),
		.divisor  (act_size),
		.done     (div_done),
		.rem      (home)
	);

	// probe i+1 = probe i + (2i+1), kept reduced mod size
	assign pos_sum = {1'b0, pos_q} + {1'b0, step_q};
	assign pos_nxt = (pos_sum >= {1'b0, act_size}) ?
		SIZE_W'(pos_sum - {1'b0, act_size}) : pos_sum[SIZE_W-1:0];
	assign step_a  = {1'b0, step_q} + (SIZE_W+1)'(2);
	// second reduction only matters for a size of one
	assign step_b  = (step_a >= {1'b0, act_size}) ? step_a - {1'b0, act_size} : step_a;
	assign step_nxt = (step_b >= {1'b0, act_size}) ?
		SIZE_W'(step_b - {1'b0, act_size}) : step_b[SIZE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= SIZE_RESET;
			count_q      <= '0;
			clr_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				table_size_q <= cfg_wr_data;
			end
			if (cmd.wr_ins) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.wr_del && count_q != '0) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			action_q <= in_action;
			key_q    <= in_key;
		end
		if (cmd.probe_init) begin
			pos_q  <= home;
			step_q <= (act_size == SIZE_W'(1)) ? '0 : SIZE_W'(1);
			iter_q <= '0;
		end else if (cmd.probe_next) begin
			pos_q  <= pos_nxt;
			step_q <= step_nxt;
			iter_q <= iter_q + 1'b1;
		end
		if (cmd.rsp_load) begin
			out_status_q <= cmd.rsp_status;
			out_found_q  <= cmd.rsp_found;
			out_slot_q   <= cmd.rsp_use_slot ? SLOT_W'(pos_q) : '0;
			out_count_q  <= count_q;
		end
	end

	always_comb begin
		mem_we    = cmd.clr_wr | cmd.wr_ins | cmd.wr_del;
		mem_waddr = AW'(pos_q);
		mem_wdata = {TAG_USED, key_q};
		if (cmd.clr_wr) begin
			mem_waddr = clr_q;
			mem_wdata = {TAG_EMPTY, key_q};
		end else if (cmd.wr_del) begin
			mem_wdata = {TAG_GONE, key_q};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[AW'(pos_q)];
		end
	end

	assign sts.action     = action_q;
	assign sts.div_done   = div_done;
	assign sts.clr_last   = (clr_q == ClrLast);
	assign sts.tag        = rd_q[WordW-1:KEY_W];
	assign sts.key_match  = (rd_q[KEY_W-1:0] == key_q);
	assign sts.probe_last = (iter_q == act_size - 1'b1);
	assign sts.is_full    = (count_q >= act_size);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_found       = out_found_q;
	assign out_slot_index  = out_slot_q;
	assign out_entry_count = out_count_q;
endmodule

[rtl/core/qph_ctrl.sv]
module qph_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  qph_pkg::qph_sts_t  sts,
	output qph_pkg::qph_cmd_t  cmd
);
	import qph_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_RD    = 3'd4;
	localparam logic [2:0] S_CHK   = 3'd5;
	localparam logic [2:0] S_RSP   = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	status_t    rsp_status_q;
	logic       rsp_found_q;
	logic       rsp_slot_q;
	logic       rsp_set;
	status_t    rsp_status;
	logic       rsp_found;
	logic       rsp_slot;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd        = '0;
		state_nxt  = state_q;
		rsp_set    = 1'b0;
		rsp_status = ST_DONE;
		rsp_found  = 1'b0;
		rsp_slot   = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = S_START;
				end
			end
			S_START: begin
				if (sts.action == ACT_NOP) begin
					rsp_set   = 1'b1;
					state_nxt = S_RSP;
				end else if (sts.action == ACT_INSERT && sts.is_full) begin
					rsp_set    = 1'b1;
					rsp_status = ST_FULL;
					state_nxt  = S_RSP;
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_done) begin
					cmd.probe_init = 1'b1;
					state_nxt      = S_RD;
				end
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_nxt  = S_CHK;
			end
			S_CHK: begin
				if (sts.action == ACT_INSERT) begin
					if (sts.tag != TAG_USED) begin
						cmd.wr_ins = 1'b1;
						rsp_set    = 1'b1;
						rsp_slot   = 1'b1;
						state_nxt  = S_RSP;
					end else if (sts.probe_last) begin
						rsp_set    = 1'b1;
						rsp_status = ST_NO_SLOT;
						state_nxt  = S_RSP;
					end else begin
						cmd.probe_next = 1'b1;
						state_nxt      = S_RD;
					end
				end else begin
					if (sts.tag == TAG_EMPTY) begin
						rsp_set    = 1'b1;
						rsp_status = ST_MISS;
						state_nxt  = S_RSP;
					end else if (sts.tag == TAG_USED && sts.key_match) begin
						cmd.wr_del = (sts.action == ACT_DELETE);
						rsp_set    = 1'b1;
						rsp_found  = 1'b1;
						rsp_slot   = 1'b1;
						state_nxt  = S_RSP;
					end else if (sts.probe_last) begin
						rsp_set    = 1'b1;
						rsp_status = ST_MISS;
						state_nxt  = S_RSP;
					end else begin
						cmd.probe_next = 1'b1;
						state_nxt      = S_RD;
					end
				end
			end
			S_RSP: begin
				// wait for the output register to drain
				if (sts.out_free) begin
					cmd.rsp_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
		cmd.rsp_status   = rsp_status_q;
		cmd.rsp_found    = rsp_found_q;
		cmd.rsp_use_slot = rsp_slot_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			rsp_status_q <= ST_DONE;
			rsp_found_q  <= 1'b0;
			rsp_slot_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (rsp_set) begin
				rsp_status_q <= rsp_status;
				rsp_found_q  <= rsp_found;
				rsp_slot_q   <= rsp_slot;
			end
		end
	end
endmodule

[rtl/core/quadratic_probe_hash_table.sv]
// channel   dir  beat payload                                  handshake
// req       in   action[1:0], key[31:0] signed                 valid/ready
// rsp       out  status[1:0], found, slot_index[9:0],          valid/ready
//                entry_count[10:0]
// cfg       in   cfg_wr_data[10:0] = table_size                cfg_wr_en, no wait
//
// one request at a time: accept, decode (a nop or a full-table insert goes straight to rsp), then
// the home slot remainder from the 32-step bit-serial divider, then per probe a registered
// table read and a check, and last the load of the output register
// after reset the tag store is swept to empty, one slot a cycle, with req.ready
// low until every slot is cleared; cfg writes are taken during the sweep
// a full output register holds the finished beat; the next request is taken
// meanwhile and waits in its last step until rsp drains
module quadratic_probe_hash_table #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	qph_req_if.sink                       req,
	qph_rsp_if.source                     rsp,
	input  logic                          cfg_wr_en,
	input  logic [qph_pkg::SIZE_W-1:0]    cfg_wr_data
);
	import qph_pkg::*;

	qph_cmd_t cmd;
	qph_sts_t sts;
	logic     in_ready;

	assign req.ready = in_ready;

	qph_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qph_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_action       (req.action),
		.in_key          (req.key),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_found       (rsp.found),
		.out_slot_index  (rsp.slot_index),
		.out_entry_count (rsp.entry_count)
	);

	// only one request in flight
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while another is in flight");

	// insert only lands on a slot that is not in use
	a_ins_free_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_ins |-> sts.tag != TAG_USED)
		else $error("insert overwrote an occupied slot");

	// a match always reports done
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rsp_load && cmd.rsp_found |-> cmd.rsp_status == ST_DONE)
		else $error("found result with failure status");

	// no table write while a request is being taken
	a_no_wr_at_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |-> !(cmd.wr_ins || cmd.wr_del || cmd.clr_wr))
		else $error("table written while accepting a request");
endmodule
